@@ design/sqt_pkg.sv @@
// shared types, codes and byte constants for the shell quote tokenizer
package sqt_pkg;

	// number of results one input byte can cause
	localparam int MAX_RES = 3;

	// quoting context
	typedef enum logic [1:0] {
		MODE_UNQ = 2'd0,
		MODE_SQ  = 2'd1,
		MODE_DQ  = 2'd2
	} mode_t;

	// result kinds
	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_END   = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// byte codes with special meaning
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_BQUOTE = 8'h60;
	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0d;

	typedef struct packed {
		mode_t mode;
		logic  esc;
		logic  word_open;
	} state_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] word_byte;
	} result_t;

	// everything one byte produces: results, their count and the next state
	typedef struct packed {
		result_t [MAX_RES-1:0] res;
		logic [1:0]            cnt;
		state_t                nxt;
	} step_t;

	// ascii whitespace: space, tab, newline, vertical tab, form feed, return
	function automatic logic is_sep(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	// bytes a backslash escapes inside double quotes
	function automatic logic is_dq_esc(input logic [7:0] c);
		return (c == CH_DQUOTE) || (c == CH_BSLASH) || (c == CH_DOLLAR) ||
			(c == CH_BQUOTE) || (c == CH_NL);
	endfunction

endpackage

@@ design/sqt_if.sv @@
// valid/ready channel interfaces for command bytes and tokenizer results
interface sqt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       final_byte;

	modport source (output valid, output ch, output final_byte, input ready);
	modport sink (input valid, input ch, input final_byte, output ready);
endinterface

interface sqt_tok_if;
	logic           valid;
	logic           ready;
	sqt_pkg::kind_t kind;
	logic [7:0]     word_byte;
	logic           run_end;

	modport source (output valid, output kind, output word_byte, output run_end, input ready);
	modport sink (input valid, input kind, input word_byte, input run_end, output ready);
endinterface

@@ design/shell_quote_tokenizer_core.sv @@
// top level of the shell quote tokenizer
// Splits a command line into shell words, one byte per transfer on cmd.
// cmd carries ch and final_byte; final_byte marks the last byte of a line.
// tok carries results: kind (word byte, end of word, unterminated quote),
// word_byte, and run_end on the last result caused by one input byte.
// An accepted byte is held in the input register and decoded from it; its
// results are then loaded into the result register, from which they transfer.
// Throughput is one byte per cycle while tok does not stall and each byte
// causes at most one result; a byte causing more results holds the output
// port until all have transferred, since the result register drains one
// result per cycle while tok is ready. Bytes with no results (quotes, pending
// backslash, repeated whitespace) pass without waiting on tok.
// When tok stalls, the result register holds its entry and the input register
// keeps the next byte; cmd.ready falls only when both are occupied.
// Reset clears the quoting state and empties both registers. After each final
// byte the quoting state returns to its reset value for the next line.
module shell_quote_tokenizer_core (
	input  logic    clk,
	input  logic    arst_n,
	sqt_byte_if.sink  cmd,
	sqt_tok_if.source tok
);

	logic            valid_s1;
	logic [7:0]      ch_s1;
	logic            final_s1;
	sqt_pkg::state_t state_q;
	sqt_pkg::step_t  step;
	logic            buf_free;
	logic            advance;
	logic            load;

	// decode of the held byte
	sqt_step u_step (
		.cur        (state_q),
		.ch         (ch_s1),
		.final_byte (final_s1),
		.step       (step)
	);

	// a byte with no results never waits for the result register
	assign advance   = valid_s1 && ((step.cnt == 2'd0) || buf_free);
	assign load      = advance && (step.cnt != 2'd0);
	assign cmd.ready = !valid_s1 || advance;

	// input register payload
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			ch_s1    <= cmd.ch;
			final_s1 <= cmd.final_byte;
		end
	end

	// input register valid and quoting state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '{mode: sqt_pkg::MODE_UNQ, esc: 1'b0, word_open: 1'b0};
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (advance) begin
				state_q <= step.nxt;
			end
		end
	end

	// result register and output side
	sqt_result_buf u_result_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.load_res (step.res),
		.load_cnt (step.cnt),
		.free     (buf_free),
		.tok      (tok)
	);

`ifndef SYNTHESIS
	// a finished line leaves the quoting state at its reset value
	a_line_reset: assert property (@(posedge clk) disable iff (!arst_n)
		advance && final_s1 |=> (state_q.mode == sqt_pkg::MODE_UNQ) && !state_q.esc &&
			!state_q.word_open)
		else $error("quoting state not cleared after final byte");

	// single quotes never leave a backslash pending
	a_no_sq_escape: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q.esc && (state_q.mode == sqt_pkg::MODE_SQ)))
		else $error("escape pending inside single quotes");

	// an error result always closes the run of its byte
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok.valid && (tok.kind == sqt_pkg::KIND_ERROR) |-> tok.run_end)
		else $error("error result not last of its byte");

	// results are loaded only into an empty or draining result register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!tok.valid || (tok.ready && tok.run_end)))
		else $error("result register overwritten");
`endif

endmodule

@@ design/sqt_step.sv @@
// per-byte decode: results and next quoting state for one command byte
module sqt_step (
	input  sqt_pkg::state_t cur,
	input  logic [7:0]      ch,
	input  logic            final_byte,
	output sqt_pkg::step_t  step
);

	sqt_pkg::state_t                        st;
	sqt_pkg::result_t [sqt_pkg::MAX_RES-1:0] r;
	logic [1:0]                             n;

	always_comb begin
		st = cur;
		r  = '0;
		n  = 2'd0;

		// byte after a backslash
		if (cur.esc) begin
			st.esc = 1'b0;
			if (cur.mode == sqt_pkg::MODE_DQ) begin
				if (sqt_pkg::is_dq_esc(ch)) begin
					if (ch != sqt_pkg::CH_NL) begin
						r[n] = '{kind: sqt_pkg::KIND_BYTE, word_byte: ch};
						n    = n + 2'd1;
					end
				end else begin
					r[n] = '{kind: sqt_pkg::KIND_BYTE, word_byte: sqt_pkg::CH_BSLASH};
					n    = n + 2'd1;
					r[n] = '{kind: sqt_pkg::KIND_BYTE, word_byte: ch};
					n    = n + 2'd1;
				end
			end else begin
				st.mode = sqt_pkg::MODE_UNQ;
				if (ch == sqt_pkg::CH_NL) begin
					if (cur.word_open) begin
						r[n] = '{kind: sqt_pkg::KIND_END, word_byte: 8'd0};
						n    = n + 2'd1;
						st.word_open = 1'b0;
					end
				end else begin
					r[n] = '{kind: sqt_pkg::KIND_BYTE, word_byte: ch};
					n    = n + 2'd1;
					st.word_open = 1'b1;
				end
			end
		// inside single quotes
		end else if (cur.mode == sqt_pkg::MODE_SQ) begin
			if (ch == sqt_pkg::CH_SQUOTE) begin
				st.mode = sqt_pkg::MODE_UNQ;
			end else begin
				r[n] = '{kind: sqt_pkg::KIND_BYTE, word_byte: ch};
				n    = n + 2'd1;
			end
		// inside double quotes
		end else if (cur.mode == sqt_pkg::MODE_DQ) begin
			if ((ch == sqt_pkg::CH_BSLASH) && !final_byte) begin
				st.esc = 1'b1;
			end else if (ch == sqt_pkg::CH_DQUOTE) begin
				st.mode = sqt_pkg::MODE_UNQ;
			end else begin
				r[n] = '{kind: sqt_pkg::KIND_BYTE, word_byte: ch};
				n    = n + 2'd1;
			end
		// unquoted
		end else begin
			st.mode = sqt_pkg::MODE_UNQ;
			if ((ch == sqt_pkg::CH_BSLASH) && !final_byte) begin
				st.esc = 1'b1;
			end else if (ch == sqt_pkg::CH_SQUOTE) begin
				st.mode      = sqt_pkg::MODE_SQ;
				st.word_open = 1'b1;
			end else if (ch == sqt_pkg::CH_DQUOTE) begin
				st.mode      = sqt_pkg::MODE_DQ;
				st.word_open = 1'b1;
			end else if (sqt_pkg::is_sep(ch)) begin
				if (cur.word_open) begin
					r[n] = '{kind: sqt_pkg::KIND_END, word_byte: 8'd0};
					n    = n + 2'd1;
					st.word_open = 1'b0;
				end
			end else begin
				r[n] = '{kind: sqt_pkg::KIND_BYTE, word_byte: ch};
				n    = n + 2'd1;
				st.word_open = 1'b1;
			end
		end

		// end of the command line: close the word or flag an open quote
		if (final_byte) begin
			if ((st.mode == sqt_pkg::MODE_SQ) || (st.mode == sqt_pkg::MODE_DQ)) begin
				r[n] = '{kind: sqt_pkg::KIND_ERROR, word_byte: 8'd0};
				n    = n + 2'd1;
			end else if (st.word_open) begin
				r[n] = '{kind: sqt_pkg::KIND_END, word_byte: 8'd0};
				n    = n + 2'd1;
			end
			st = '{mode: sqt_pkg::MODE_UNQ, esc: 1'b0, word_open: 1'b0};
		end
	end

	assign step.res = r;
	assign step.cnt = n;
	assign step.nxt = st;

endmodule

@@ design/sqt_result_buf.sv @@
// result register: holds up to three results of one byte and hands them out in order
module sqt_result_buf (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    load,
	input  sqt_pkg::result_t [sqt_pkg::MAX_RES-1:0] load_res,
	input  logic [1:0]                              load_cnt,
	output logic                                    free,
	sqt_tok_if.source                               tok
);

	sqt_pkg::result_t [sqt_pkg::MAX_RES-1:0] ent_q;
	logic [1:0]                              cnt_q;
	logic [1:0]                              idx_q;
	logic                                    last_ent;
	logic                                    xfer;

	assign last_ent = (idx_q == (cnt_q - 2'd1));
	assign xfer     = tok.valid && tok.ready;
	assign free     = (cnt_q == 2'd0) || (xfer && last_ent);

	// present the current entry
	assign tok.valid     = (cnt_q != 2'd0);
	assign tok.kind      = ent_q[idx_q].kind;
	assign tok.word_byte = ent_q[idx_q].word_byte;
	assign tok.run_end   = last_ent;

	// entry payload
	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= load_res;
		end
	end

	// fill count and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= load_cnt;
			idx_q <= 2'd0;
		end else if (xfer) begin
			if (last_ent) begin
				cnt_q <= 2'd0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

@@ bench/sqt_token_compare.sv @@
// result predictor and comparator for the shell quote tokenizer channels
module sqt_token_compare
	import sqt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  logic       cmd_ready,
	input  logic [7:0] cmd_ch,
	input  logic       cmd_final,
	input  logic       tok_valid,
	input  logic       tok_ready,
	input  kind_t      tok_kind,
	input  logic [7:0] tok_word_byte,
	input  logic       tok_run_end,
	output int         mismatches,
	output int         pending,
	output int         compared
);

	typedef struct packed {
		kind_t      kind;
		logic [7:0] word_byte;
		logic       run_end;
	} tok_exp_t;

	// predicted tokenizer state
	mode_t qmode;
	logic  esc_pend;
	logic  in_word;

	// results still owed by the block, oldest first
	tok_exp_t tok_q [$];

	function automatic tok_exp_t mk_tok(input kind_t k, input logic [7:0] b);
		tok_exp_t t;
		t.kind = k;
		t.word_byte = b;
		t.run_end = 1'b0;
		return t;
	endfunction

	// work out the results of one command byte and advance the state
	function automatic void predict_tokens(input logic [7:0] c, input logic last);
		tok_exp_t fresh [$];
		tok_exp_t tail;
		if (esc_pend) begin
			esc_pend = 1'b0;
			if (qmode == MODE_DQ) begin
				if (c == CH_DQUOTE || c == CH_BSLASH || c == CH_DOLLAR ||
					c == CH_BQUOTE || c == CH_NL) begin
					// escaped newline vanishes inside double quotes
					if (c != CH_NL)
						fresh.push_back(mk_tok(KIND_BYTE, c));
				end else begin
					// backslash is kept before a non-special byte
					fresh.push_back(mk_tok(KIND_BYTE, CH_BSLASH));
					fresh.push_back(mk_tok(KIND_BYTE, c));
				end
			end else begin
				qmode = MODE_UNQ;
				if (c == CH_NL) begin
					// backslash-newline splits words like whitespace
					if (in_word)
						fresh.push_back(mk_tok(KIND_END, 8'h00));
					in_word = 1'b0;
				end else begin
					fresh.push_back(mk_tok(KIND_BYTE, c));
					in_word = 1'b1;
				end
			end
		end else if (qmode == MODE_SQ) begin
			if (c == CH_SQUOTE)
				qmode = MODE_UNQ;
			else
				fresh.push_back(mk_tok(KIND_BYTE, c));
		end else if (qmode == MODE_DQ) begin
			if (c == CH_BSLASH && !last)
				esc_pend = 1'b1;
			else if (c == CH_DQUOTE)
				qmode = MODE_UNQ;
			else
				fresh.push_back(mk_tok(KIND_BYTE, c));
		end else begin
			qmode = MODE_UNQ;
			if (c == CH_BSLASH && !last) begin
				esc_pend = 1'b1;
			end else if (c == CH_SQUOTE) begin
				qmode = MODE_SQ;
				in_word = 1'b1;
			end else if (c == CH_DQUOTE) begin
				qmode = MODE_DQ;
				in_word = 1'b1;
			end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
				if (in_word)
					fresh.push_back(mk_tok(KIND_END, 8'h00));
				in_word = 1'b0;
			end else begin
				fresh.push_back(mk_tok(KIND_BYTE, c));
				in_word = 1'b1;
			end
		end

		// end of line: open quote is an error, else close any open word
		if (last) begin
			if (qmode == MODE_SQ || qmode == MODE_DQ)
				fresh.push_back(mk_tok(KIND_ERROR, 8'h00));
			else if (in_word)
				fresh.push_back(mk_tok(KIND_END, 8'h00));
			qmode = MODE_UNQ;
			esc_pend = 1'b0;
			in_word = 1'b0;
		end

		// mark the last result of this byte
		if (fresh.size() > 0) begin
			tail = fresh.pop_back();
			tail.run_end = 1'b1;
			fresh.push_back(tail);
		end
		foreach (fresh[i])
			tok_q.push_back(fresh[i]);
	endfunction

	// compare result transfers, then predict from command transfers
	always @(posedge clk or negedge arst_n) begin
		tok_exp_t want;
		if (!arst_n) begin
			qmode = MODE_UNQ;
			esc_pend = 1'b0;
			in_word = 1'b0;
			tok_q.delete();
			mismatches = 0;
			pending = 0;
			compared = 0;
		end else begin
			if (tok_valid && tok_ready) begin
				compared++;
				if (tok_q.size() == 0) begin
					if (mismatches < 10)
						$display("tok transfer with nothing expected: kind %0d byte %02h end %0b",
							tok_kind, tok_word_byte, tok_run_end);
					mismatches++;
				end else begin
					want = tok_q.pop_front();
					if (tok_kind !== want.kind || tok_word_byte !== want.word_byte ||
						tok_run_end !== want.run_end) begin
						if (mismatches < 10)
							$display("tok mismatch: expected kind %0d byte %02h end %0b, got kind %0d byte %02h end %0b",
								want.kind, want.word_byte, want.run_end,
								tok_kind, tok_word_byte, tok_run_end);
						mismatches++;
					end
				end
			end
			if (cmd_valid && cmd_ready)
				predict_tokens(cmd_ch, cmd_final);
			pending = tok_q.size();
		end
	end

endmodule

@@ bench/shell_quote_tokenizer_core_test.sv @@
// stimulus, clocking and verdict for the shell quote tokenizer core
module shell_quote_tokenizer_core_test;
	import sqt_pkg::*;

	logic clk;
	logic arst_n;

	sqt_byte_if cmd_ch ();
	sqt_tok_if  tok_ch ();

	int mismatches;
	int pending;
	int compared;

	// sender and receiver pacing
	logic tx_idle_on;
	logic rx_stall_on;
	int   burst_left;
	int   bytes_sent;
	int   lines_sent;
	int   holdoffs;

	// bytes of the command line being built
	logic [7:0] line_q [$];

	shell_quote_tokenizer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.tok    (tok_ch)
	);

	sqt_token_compare tok_watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_ch.valid),
		.cmd_ready     (cmd_ch.ready),
		.cmd_ch        (cmd_ch.ch),
		.cmd_final     (cmd_ch.final_byte),
		.tok_valid     (tok_ch.valid),
		.tok_ready     (tok_ch.ready),
		.tok_kind      (tok_ch.kind),
		.tok_word_byte (tok_ch.word_byte),
		.tok_run_end   (tok_ch.run_end),
		.mismatches    (mismatches),
		.pending       (pending),
		.compared      (compared)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#600000;
		$display("shell_quote_tokenizer_core verification failed");
		$finish;
	end

	// result receiver with random stall stretches
	initial begin
		int stall_left;
		stall_left = 0;
		tok_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!rx_stall_on) begin
				stall_left = 0;
				tok_ch.ready = 1'b1;
			end else if (stall_left > 0) begin
				tok_ch.ready = 1'b0;
				stall_left--;
			end else begin
				tok_ch.ready = 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = $urandom_range(1, 7);
			end
		end
	end

	// one command byte transfer, sender idles between bursts when tx_idle_on is set
	task automatic send_cmd_byte(input logic [7:0] c, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = tx_idle_on ? $urandom_range(1, 6) : 0;
			if (gap > 0) begin
				cmd_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		cmd_ch.valid = 1'b1;
		cmd_ch.ch = c;
		cmd_ch.final_byte = last;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		burst_left--;
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_line();
		for (int i = 0; i < line_q.size(); i++)
			send_cmd_byte(line_q[i], i == line_q.size() - 1);
		lines_sent++;
	endtask

	// hold the sender off until every owed result has come out
	task automatic drain_results();
		cmd_ch.valid = 1'b0;
		burst_left = 0;
		while (pending != 0)
			@(negedge clk);
		holdoffs++;
	endtask

	// ordinary word byte: no separator, quote or backslash
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do begin
			if ($urandom_range(0, 1) == 1)
				b = 8'($urandom_range(97, 122));
			else
				b = 8'($urandom_range(0, 255));
		end while (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR) || b == CH_SQUOTE ||
			b == CH_DQUOTE || b == CH_BSLASH);
		return b;
	endfunction

	function automatic logic [7:0] sep_byte();
		case ($urandom_range(0, 5))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_NL;
			3: return 8'h0b;
			4: return 8'h0c;
			default: return CH_CR;
		endcase
	endfunction

	// byte following a backslash inside double quotes
	function automatic logic [7:0] dq_escaped();
		case ($urandom_range(0, 5))
			0: return CH_DQUOTE;
			1: return CH_BSLASH;
			2: return CH_DOLLAR;
			3: return CH_BQUOTE;
			4: return CH_NL;
			default: return plain_byte();
		endcase
	endfunction

	// mostly well-formed lines of random words, some noise, open quotes and trailing backslashes
	task automatic build_line();
		int shape;
		int pieces;
		logic [7:0] b;
		line_q.delete();
		shape = $urandom_range(0, 9);
		if (shape == 0) begin
			repeat ($urandom_range(1, 12))
				line_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			pieces = $urandom_range(1, 6);
			repeat (pieces) begin
				case ($urandom_range(0, 4))
					0: begin
						repeat ($urandom_range(1, 4))
							line_q.push_back(plain_byte());
					end
					1: begin
						line_q.push_back(CH_SQUOTE);
						repeat ($urandom_range(0, 4)) begin
							b = 8'($urandom_range(0, 255));
							line_q.push_back(b == CH_SQUOTE ? plain_byte() : b);
						end
						line_q.push_back(CH_SQUOTE);
					end
					2: begin
						line_q.push_back(CH_DQUOTE);
						repeat ($urandom_range(0, 4)) begin
							if ($urandom_range(0, 2) == 0) begin
								line_q.push_back(CH_BSLASH);
								line_q.push_back(dq_escaped());
							end else begin
								line_q.push_back(plain_byte());
							end
						end
						line_q.push_back(CH_DQUOTE);
					end
					3: begin
						line_q.push_back(CH_BSLASH);
						if ($urandom_range(0, 3) == 0)
							line_q.push_back(CH_NL);
						else
							line_q.push_back(8'($urandom_range(0, 255)));
					end
					default: begin
						repeat ($urandom_range(1, 2))
							line_q.push_back(sep_byte());
					end
				endcase
			end
			// open quote left unclosed, or a trailing backslash
			if (shape == 1) begin
				line_q.push_back($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
				repeat ($urandom_range(0, 3))
					line_q.push_back(plain_byte());
			end else if (shape == 2) begin
				line_q.push_back(CH_BSLASH);
			end
		end
	endtask

	// main stimulus
	initial begin
		int rand_start;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.ch = 8'h00;
		cmd_ch.final_byte = 1'b0;
		tx_idle_on = 1'b1;
		rx_stall_on = 1'b1;
		burst_left = 0;
		bytes_sent = 0;
		lines_sent = 0;
		holdoffs = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// extreme bytes, escaped space, backslash-newline, empty single quotes,
		// double quote escapes special and plain, escaped newline in quotes,
		// trailing backslash as a literal
		line_q = '{8'h00, 8'hff, CH_BSLASH, CH_SPACE, CH_BSLASH, CH_NL,
			CH_SQUOTE, CH_SQUOTE, CH_TAB, CH_DQUOTE, CH_BSLASH, CH_DOLLAR,
			CH_BSLASH, CH_DQUOTE, CH_BSLASH, CH_BQUOTE, CH_BSLASH, 8'h71,
			CH_BSLASH, CH_NL, CH_DQUOTE, CH_BSLASH};
		send_line();
		// trailing backslash inside an open double quote
		line_q = '{CH_DQUOTE, CH_BSLASH};
		send_line();
		// lone open single quote
		line_q = '{CH_SQUOTE};
		send_line();
		// empty double quotes and the remaining separators
		line_q = '{CH_DQUOTE, CH_DQUOTE, 8'h0b, 8'h7a, 8'h0c, CH_CR};
		send_line();
		drain_results();

		// random lines with changing pacing
		rand_start = bytes_sent;
		while (bytes_sent - rand_start < 320) begin
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_stall_on = ($urandom_range(0, 3) != 0);
			build_line();
			send_line();
			if (lines_sent % 5 == 0)
				drain_results();
		end

		cmd_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);

		$display("run: %0d command bytes in %0d lines, %0d results compared, %0d hold-offs",
			bytes_sent, lines_sent, compared, holdoffs);
		if (mismatches == 0)
			$display("shell_quote_tokenizer_core verification clean");
		else
			$display("shell_quote_tokenizer_core verification failed");
		$finish;
	end

endmodule

@@ shell_quote_tokenizer_core.f @@
design/sqt_pkg.sv
design/sqt_if.sv
design/sqt_step.sv
design/sqt_result_buf.sv
design/shell_quote_tokenizer_core.sv
bench/sqt_token_compare.sv
bench/shell_quote_tokenizer_core_test.sv
